FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, sampled on clk, off during reset
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: design/aes_pkg.sv
`timescale 1ns / 1ps
package aes_pkg;

  typedef enum logic [2:0] {
    S_IDLE, S_EXPAND, S_START, S_ADD0, S_ROUND, S_DONE
  } state_t;

  localparam logic [2:0] REG_KEY_SIZE = 3'd0;
  localparam logic [2:0] REG_KEY_0    = 3'd1;
  localparam logic [2:0] REG_KEY_1    = 3'd2;
  localparam logic [2:0] REG_KEY_2    = 3'd3;
  localparam logic [2:0] REG_KEY_3    = 3'd4;

  localparam logic [1:0] KS_128 = 2'd0;
  localparam logic [1:0] KS_192 = 2'd1;
  localparam logic [1:0] KS_256 = 2'd2;
  localparam logic [1:0] KS_BAD = 2'd3;

  localparam logic [7:0] SBOX_FWD [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] SBOX_INV [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] MIX_FWD [4] = '{8'h02, 8'h03, 8'h01, 8'h01};
  localparam logic [7:0] MIX_INV [4] = '{8'h0e, 8'h0b, 8'h0d, 8'h09};

  function automatic logic [7:0] xt(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ x;
      x = xt(x);
    end
    return acc;
  endfunction

  function automatic logic [31:0] subst_word(input logic [31:0] w);
    return {SBOX_FWD[w[31:24]], SBOX_FWD[w[23:16]], SBOX_FWD[w[15:8]], SBOX_FWD[w[7:0]]};
  endfunction

  // byte n of a block sits at bits 127-8n down; byte 4c+r is column c, row r
  function automatic logic [127:0] sub_shift_fwd(input logic [127:0] s);
    logic [127:0] o;
    o = '0;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[127-8*(4*c+r) -: 8] = SBOX_FWD[s[127-8*(4*((c+r)%4)+r) -: 8]];
    return o;
  endfunction

  function automatic logic [127:0] sub_shift_inv(input logic [127:0] s);
    logic [127:0] o;
    o = '0;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[127-8*(4*((c+r)%4)+r) -: 8] = SBOX_INV[s[127-8*(4*c+r) -: 8]];
    return o;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    logic [7:0] acc;
    o = '0;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++)
          acc = acc ^ gmul(s[127-8*(4*c+k) -: 8],
                           inv ? MIX_INV[(k+4-r)%4] : MIX_FWD[(k+4-r)%4]);
        o[127-8*(4*c+r) -: 8] = acc;
      end
    return o;
  endfunction

endpackage

FILE: design/aes_block_cipher_unit.sv
// AES-128/192/256 block cipher, one 128-bit block per item, electronic codebook.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes key_size
// (index 0) and the four 64-bit key words (indexes 1 to 4); cfg_ready is always
// high, so writes must only be sent while no item is in flight. A write to any
// of these registers drops the round-key schedule; other indexes are ignored.
// Input channel (in_valid/in_ready): operation, block_high, block_low.
// Output channel (out_valid/out_ready): result_high, result_low.
// The first item after reset or after a write to one of these registers first
// expands the schedule, one key word a cycle into a row-per-round memory.
// After that an item passes from acceptance through the start, first key-add,
// Nr round and done states (Nr = 10, 12 or 14) to out_valid, one round a cycle
// through a single round unit fed by the key memory read port; the next item
// is taken in the cycle after the result is registered, so items do not overlap.
// A result waits in the output register while out_ready is low; the block
// holds the next finished block until it is free.
// Reset is synchronous: state idle, output empty, schedule invalid, key zero, 128-bit.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aes_block_cipher_unit
  import aes_pkg::*;
#(
  parameter int MAX_ROUND_COUNT = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_high,
  output logic [63:0] result_low
);

  localparam int ROWS = MAX_ROUND_COUNT + 1;
  localparam int RA_W = $clog2(ROWS);
  localparam int WI_W = $clog2(4 * ROWS);

  state_t state, state_next;

  logic [1:0]   key_size;
  logic [63:0]  key_regs [4];
  logic         sched_ready;

  logic [127:0] rk_mem [ROWS];
  logic [127:0] rdata;
  logic [RA_W-1:0] raddr;
  logic         mem_we;

  logic [WI_W-1:0] wi;
  logic [2:0]   kmod;
  logic [7:0]   rcon;
  logic [31:0]  win [8];
  logic [95:0]  rowacc;
  logic [31:0]  word;
  logic [31:0]  back_word;
  logic         key_phase;

  logic [3:0]   nk;
  logic [3:0]   nr;
  logic [3:0]   cnt;
  logic         op;
  logic [127:0] blk;
  logic [127:0] round_out;
  logic         last_word;
  logic         last_round;

  always_comb begin
    case (key_size)
      KS_192:  nk = 4'd6;
      KS_256:  nk = 4'd8;
      default: nk = 4'd4;
    endcase
    nr = (32'(nk) + 32'd6 > 32'(MAX_ROUND_COUNT)) ? 4'(MAX_ROUND_COUNT) : nk + 4'd6;
  end

  assign cfg_ready  = 1'b1;
  assign last_word  = (wi == WI_W'({nr, 2'b11}));
  assign last_round = (cnt == nr);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_size <= KS_128;
      for (int i = 0; i < 4; i++) key_regs[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_SIZE: key_size <= (cfg_data[1:0] == KS_BAD) ? KS_128 : cfg_data[1:0];
        REG_KEY_0:    key_regs[0] <= cfg_data;
        REG_KEY_1:    key_regs[1] <= cfg_data;
        REG_KEY_2:    key_regs[2] <= cfg_data;
        REG_KEY_3:    key_regs[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // key expansion word
  always_comb begin
    logic [31:0] t;
    logic [63:0] kr;
    key_phase = ({1'b0, wi} < (WI_W+1)'(nk));
    case (nk)
      4'd6:    back_word = win[5];
      4'd8:    back_word = win[7];
      default: back_word = win[3];
    endcase
    kr = key_regs[wi[2:1]];
    t = win[0];
    if (kmod == 3'd0) t = subst_word({t[23:0], t[31:24]}) ^ {rcon, 24'h000000};
    else if (nk == 4'd8 && kmod == 3'd4) t = subst_word(t);
    word = key_phase ? (wi[0] ? kr[31:0] : kr[63:32]) : (back_word ^ t);
  end

  assign mem_we = (state == S_EXPAND) && (wi[1:0] == 2'b11);

  // round datapath
  always_comb begin
    logic [127:0] t;
    if (!op) begin
      t = sub_shift_fwd(blk);
      if (!last_round) t = mix_cols(t, 1'b0);
      round_out = t ^ rdata;
    end else begin
      t = sub_shift_inv(blk) ^ rdata;
      round_out = last_round ? t : mix_cols(t, 1'b1);
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    raddr      = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = sched_ready ? S_START : S_EXPAND;
      end
      S_EXPAND: if (last_word) state_next = S_START;
      S_START: begin
        raddr = op ? RA_W'(nr) : '0;
        state_next = S_ADD0;
      end
      S_ADD0: begin
        raddr = op ? RA_W'(nr - 4'd1) : RA_W'(1);
        state_next = S_ROUND;
      end
      S_ROUND: begin
        // no look-ahead read after the last round
        if (!last_round) raddr = op ? RA_W'(nr - cnt - 4'd1) : RA_W'(cnt + 4'd1);
        if (last_round) state_next = S_DONE;
      end
      S_DONE: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) rk_mem[wi[WI_W-1:2]] <= {rowacc, word};
    rdata <= rk_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sched_ready <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index <= REG_KEY_3) sched_ready <= 1'b0;
      else if (state == S_EXPAND && last_word) sched_ready <= 1'b1;
      if (state == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op   <= operation;
        blk  <= {block_high, block_low};
        wi   <= '0;
        kmod <= '0;
        rcon <= 8'h01;
      end
      S_EXPAND: begin
        wi <= wi + WI_W'(1);
        kmod <= ({1'b0, kmod} + 4'd1 == nk) ? 3'd0 : kmod + 3'd1;
        if (!key_phase && kmod == 3'd0) rcon <= xt(rcon);
        win[0] <= word;
        for (int j = 1; j < 8; j++) win[j] <= win[j-1];
        rowacc <= {rowacc[63:0], word};
      end
      S_ADD0: begin
        blk <= blk ^ rdata;
        cnt <= 4'd1;
      end
      S_ROUND: begin
        blk <= round_out;
        cnt <= cnt + 4'd1;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          result_high <= blk[127:64];
          result_low  <= blk[63:0];
        end
      end
      default: ;
    endcase
  end

  `ASSERT_NEXT(a_expand_first, in_valid && in_ready && !sched_ready, state == S_EXPAND)
  `ASSERT_NOW(a_round_bound, state == S_ROUND, cnt >= 4'd1 && cnt <= nr)
  `ASSERT_NOW(a_sched_in_round, state == S_ROUND || state == S_START, sched_ready)

endmodule

FILE: dv/aes_checker.sv
`timescale 1ns / 1ps
module aes_checker
  import aes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        operation,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] result_high,
  input  logic [63:0] result_low,
  output int          fail_count,
  output int          pending
);

  logic [7:0]   sbox_f [256];
  logic [7:0]   sbox_i [256];
  logic [1:0]   key_len;
  logic [63:0]  key_copy [4];
  logic [31:0]  rk_words [60];
  logic         rk_valid;
  logic [127:0] cipher_results [$];

  function automatic logic [7:0] gf_dbl(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = gf_dbl(a);
    end
    return acc;
  endfunction

  // S-box built from the field inverse and the affine map
  initial begin
    logic [7:0] inv_v, s;
    for (int a = 0; a < 256; a++) begin
      inv_v = 8'h00;
      for (int b = 1; b < 256; b++)
        if (gf_mul(a[7:0], b[7:0]) == 8'h01) inv_v = b[7:0];
      s = inv_v ^ {inv_v[6:0], inv_v[7]} ^ {inv_v[5:0], inv_v[7:6]}
          ^ {inv_v[4:0], inv_v[7:5]} ^ {inv_v[3:0], inv_v[7:4]} ^ 8'h63;
      sbox_f[a] = s;
      sbox_i[s] = a[7:0];
    end
  end

  function automatic int words_in_key();
    return key_len == KS_192 ? 6 : (key_len == KS_256 ? 8 : 4);
  endfunction

  function automatic int rounds_for_key();
    return (words_in_key() + 6 > 14) ? 14 : words_in_key() + 6;
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {sbox_f[w[31:24]], sbox_f[w[23:16]], sbox_f[w[15:8]], sbox_f[w[7:0]]};
  endfunction

  function automatic void build_schedule();
    int nk, total;
    logic [31:0] t;
    logic [7:0] rc;
    nk = words_in_key();
    total = 4 * (rounds_for_key() + 1);
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      rk_words[i] = i[0] ? key_copy[i >> 1][31:0] : key_copy[i >> 1][63:32];
    for (int i = nk; i < total; i++) begin
      t = rk_words[i-1];
      if (i % nk == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_dbl(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sbox_word(t);
      end
      rk_words[i] = rk_words[i-nk] ^ t;
    end
    rk_valid = 1'b1;
  endfunction

  function automatic logic [127:0] add_rk(input logic [127:0] s, input int rnd);
    for (int c = 0; c < 4; c++) s[127-32*c -: 32] ^= rk_words[4*rnd+c];
    return s;
  endfunction

  function automatic logic [127:0] subst_shift(input logic [127:0] s, input logic dec);
    logic [127:0] o;
    o = '0;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        if (dec)
          o[127-8*(4*((c+r)%4)+r) -: 8] = sbox_i[s[127-8*(4*c+r) -: 8]];
        else
          o[127-8*(4*c+r) -: 8] = sbox_f[s[127-8*(4*((c+r)%4)+r) -: 8]];
    return o;
  endfunction

  function automatic logic [127:0] mix_model(input logic [127:0] s, input logic dec);
    logic [127:0] o;
    logic [7:0] coef [4];
    logic [7:0] acc;
    if (dec) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else     coef = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int k = 0; k < 4; k++)
          acc ^= gf_mul(s[127-8*(4*c+k) -: 8], coef[(k+4-r)%4]);
        o[127-8*(4*c+r) -: 8] = acc;
      end
    return o;
  endfunction

  function automatic logic [127:0] aes_block(input logic dec, input logic [127:0] s);
    int nr;
    if (!rk_valid) build_schedule();
    nr = rounds_for_key();
    if (!dec) begin
      s = add_rk(s, 0);
      for (int r = 1; r <= nr; r++) begin
        s = subst_shift(s, 1'b0);
        if (r != nr) s = mix_model(s, 1'b0);
        s = add_rk(s, r);
      end
    end else begin
      s = add_rk(s, nr);
      for (int r = nr - 1; r >= 1; r--) begin
        s = subst_shift(s, 1'b1);
        s = add_rk(s, r);
        s = mix_model(s, 1'b1);
      end
      s = subst_shift(s, 1'b1);
      s = add_rk(s, 0);
    end
    return s;
  endfunction

  always @(posedge clk) begin
    logic [127:0] want;
    int errs;
    errs = 0;
    if (rst) begin
      key_len = KS_128;
      key_copy = '{default: '0};
      rk_valid = 1'b0;
      cipher_results.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index <= REG_KEY_3) begin
        if (cfg_index == REG_KEY_SIZE)
          key_len = (cfg_data[1:0] == KS_BAD) ? KS_128 : cfg_data[1:0];
        else
          key_copy[cfg_index - 1] = cfg_data;
        rk_valid = 1'b0;
      end
      if (in_valid && in_ready)
        cipher_results.push_back(aes_block(operation, {block_high, block_low}));
      if (out_valid && out_ready) begin
        if (cipher_results.size() == 0) begin
          $display("%0t: unexpected item, actual %h_%h", $time, result_high, result_low);
          errs++;
        end else begin
          want = cipher_results.pop_front();
          if (want[127:64] !== result_high) begin
            $display("%0t: result_high expected %h actual %h", $time, want[127:64],
                     result_high);
            errs++;
          end
          if (want[63:0] !== result_low) begin
            $display("%0t: result_low expected %h actual %h", $time, want[63:0],
                     result_low);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      pending <= cipher_results.size();
    end
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import aes_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        operation;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  int          fail_count;
  int          pending;
  int          stall_mode;
  int          stall_cnt;

  aes_block_cipher_unit DUT (.*);
  aes_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  // receiver: out_ready follows a stall mode (always ready, random, mostly stalled) redrawn at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_cnt <= 0;
      stall_mode <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt % 64 == 63) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_key(input logic [1:0] ks, input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3);
    write_reg(REG_KEY_SIZE, {62'h0, ks});
    write_reg(REG_KEY_0, k0);
    write_reg(REG_KEY_1, k1);
    write_reg(REG_KEY_2, k2);
    write_reg(REG_KEY_3, k3);
  endtask

  // wait for every result, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo);
    in_valid <= 1'b1;
    operation <= op;
    block_high <= hi;
    block_low <= lo;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic random_blocks(input int count);
    int burst;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 2) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 30)) @(posedge clk);
        end
      end
      burst--;
      send_block(1'($urandom_range(0, 1)), {$urandom, $urandom}, {$urandom, $urandom});
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = 1'b0;
    block_high = '0;
    block_low = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset key: all zero, 128-bit
    send_block(1'b0, 64'h0, 64'h0);
    send_block(1'b1, 64'h0, 64'h0);
    drain();
    load_key(KS_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0, 64'h0);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    send_block(1'b0, '1, '1);
    send_block(1'b1, '1, '1);
    drain();
    load_key(KS_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, 64'h0);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1'b1, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    drain();
    load_key(KS_256, '1, '1, '1, '1);
    send_block(1'b0, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    send_block(1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff);
    drain();
    // unused key-size code behaves as 128-bit
    write_reg(REG_KEY_SIZE, {62'h0, KS_BAD});
    send_block(1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210);
    send_block(1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210);
    drain();
    // out-of-range indexes must be ignored
    write_reg(3'd5, '1);
    write_reg(3'd6, 64'h0);
    write_reg(3'd7, {$urandom, $urandom});
    send_block(1'b0, '0, '1);
    send_block(1'b1, '1, '0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: write_reg(REG_KEY_SIZE, {62'h0, KS_128});
        1: write_reg(REG_KEY_SIZE, {62'h0, KS_192});
        2: write_reg(REG_KEY_SIZE, {62'h0, KS_256});
        default: write_reg(REG_KEY_SIZE, {62'h0, KS_BAD});
      endcase
      for (int k = 1; k <= 4; k++)
        if (ph == 7) write_reg(k[2:0], 64'h0);
        else write_reg(k[2:0], {$urandom, $urandom});
      if ($urandom_range(0, 1)) write_reg(3'($urandom_range(5, 7)), {$urandom, $urandom});
      random_blocks(112);
      drain();
    end

    if (fail_count == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

FILE: aes_block_cipher_unit.f
+incdir+design
design/aes_pkg.sv
design/aes_block_cipher_unit.sv
dv/aes_checker.sv
dv/testbench.sv
